[rtl/epsc_pkg.sv]
// Shared constants and types for the epoch-seconds to civil-time pipeline.
// No dependencies; the day split, calendar and top-level files refer to it by scoped names.
`default_nettype none

package epsc_pkg;

	// Pipeline depth: stages 1-5 split seconds into days, stages 6-14 build the date.
	localparam int NumStages = 14;

	typedef logic [NumStages-1:0] stage_load_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
	} tod_t;

	localparam longint unsigned SecPerDay  = 64'd86400;
	localparam longint unsigned DaysPerEra = 64'd146097;
	localparam longint unsigned EpochShift = 64'd719468;

	// 86400 is 675 shifted left by 7.
	localparam longint unsigned SecOdd = 64'd675;
	localparam int              SecSh  = 7;

	// Whole days added to the seconds so that the sum is never negative.
	localparam longint unsigned BiasDays = ((64'd1 << 40) + SecPerDay - 64'd1) / SecPerDay;
	localparam longint unsigned BiasSecs = BiasDays * SecPerDay;

	// Whole eras added to the shifted day count so the era quotient is never negative.
	localparam longint unsigned EraBias = (BiasDays - EpochShift + DaysPerEra - 64'd1) / DaysPerEra;
	localparam longint unsigned DayBias = EraBias * DaysPerEra + EpochShift - BiasDays;
	localparam longint unsigned WdayBias = (64'd11 - (BiasDays % 64'd7)) % 64'd7;
	localparam longint unsigned YearBias = EraBias * 64'd400 + 64'd1900;

	// Reciprocals for exact constant division: q = (x * R) >> Sh for x below 2^n,
	// with Sh at least n plus the bit length of the divisor.
	localparam int HiSh     = 27;
	localparam int LoSh     = 38;
	localparam int EraSh    = 44;
	localparam int WdSh     = 29;
	localparam int SodSh    = 23;
	localparam int MinSh    = 17;
	localparam int C1460Sh  = 29;
	localparam int C36524Sh = 34;
	localparam int YoeSh    = 27;
	localparam int CentSh   = 16;
	localparam int MpSh     = 19;
	localparam int Md5Sh    = 14;

	localparam longint unsigned RecipHi     = ((64'd1 << HiSh) + SecOdd - 64'd1) / SecOdd;
	localparam longint unsigned RecipLo     = ((64'd1 << LoSh) + SecOdd - 64'd1) / SecOdd;
	localparam longint unsigned RecipEra    = ((64'd1 << EraSh) + DaysPerEra - 64'd1) / DaysPerEra;
	localparam longint unsigned Recip7      = ((64'd1 << WdSh) + 64'd6) / 64'd7;
	localparam longint unsigned Recip60s    = ((64'd1 << SodSh) + 64'd59) / 64'd60;
	localparam longint unsigned Recip60m    = ((64'd1 << MinSh) + 64'd59) / 64'd60;
	localparam longint unsigned Recip1460   = ((64'd1 << C1460Sh) + 64'd1459) / 64'd1460;
	localparam longint unsigned Recip36524  = ((64'd1 << C36524Sh) + 64'd36523) / 64'd36524;
	localparam longint unsigned Recip365    = ((64'd1 << YoeSh) + 64'd364) / 64'd365;
	localparam longint unsigned Recip100    = ((64'd1 << CentSh) + 64'd99) / 64'd100;
	localparam longint unsigned Recip153    = ((64'd1 << MpSh) + 64'd152) / 64'd153;
	localparam longint unsigned Recip5      = ((64'd1 << Md5Sh) + 64'd4) / 64'd5;

endpackage

`default_nettype wire

[rtl/epsc_day_split.sv]
// Stages 1 to 5: floored split of signed epoch seconds into a biased day count
// and the second of the day. Depends on epsc_pkg.
`default_nettype none

module epsc_day_split (
	input  wire logic                  clk,
	input  wire epsc_pkg::stage_load_t load,
	input  wire logic [40:0]           epoch_seconds,
	output logic      [25:0]           days_off,
	output logic      [16:0]           sod
);

	logic [41:0] u_s1;
	logic [34:0] p_hi_s2;
	logic [16:0] hi_s2;
	logic [17:0] lo_s2;
	logic [6:0]  fine_s2;
	logic [7:0]  q1_s3;
	logic [27:0] v2_s3;
	logic [6:0]  fine_s3;
	logic [56:0] p_lo_s4;
	logic [7:0]  q1_s4;
	logic [27:0] v2_s4;
	logic [6:0]  fine_s4;
	logic [25:0] days_off_s5;
	logic [16:0] sod_s5;

	logic [7:0]  q1_w;
	logic [16:0] r1_w;
	logic [17:0] q2_w;
	logic [27:0] r2_w;

	// The bias is a whole number of days, so the split of the sum matches floored division.
	always_ff @(posedge clk) begin
		if (load[0]) begin
			u_s1 <= {epoch_seconds[40], epoch_seconds} + epsc_pkg::BiasSecs[41:0];
		end
	end

	// The upper 17 bits of the seconds over 128 are divided by 675 first.
	always_ff @(posedge clk) begin
		if (load[1]) begin
			p_hi_s2 <= 35'(u_s1[41:25]) * 35'(epsc_pkg::RecipHi[17:0]);
			hi_s2   <= u_s1[41:25];
			lo_s2   <= u_s1[24:7];
			fine_s2 <= u_s1[6:0];
		end
	end

	assign q1_w = p_hi_s2[epsc_pkg::HiSh +: 8];
	assign r1_w = hi_s2 - 17'(q1_w) * 17'(epsc_pkg::SecOdd);

	always_ff @(posedge clk) begin
		if (load[2]) begin
			q1_s3   <= q1_w;
			v2_s3   <= {r1_w[9:0], lo_s2};
			fine_s3 <= fine_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load[3]) begin
			p_lo_s4 <= 57'(v2_s3) * 57'(epsc_pkg::RecipLo[28:0]);
			q1_s4   <= q1_s3;
			v2_s4   <= v2_s3;
			fine_s4 <= fine_s3;
		end
	end

	assign q2_w = p_lo_s4[epsc_pkg::LoSh +: 18];
	assign r2_w = v2_s4 - 28'(q2_w) * 28'(epsc_pkg::SecOdd);

	always_ff @(posedge clk) begin
		if (load[4]) begin
			days_off_s5 <= {q1_s4, q2_w};
			sod_s5      <= {r2_w[9:0], fine_s4};
		end
	end

	assign days_off = days_off_s5;
	assign sod      = sod_s5;

endmodule

`default_nettype wire

[rtl/epsc_calendar.sv]
// Stages 6 to 14: era-based civil date, weekday and time of day from the biased
// day count and the second of the day. Depends on epsc_pkg.
`default_nettype none

module epsc_calendar (
	input  wire logic                  clk,
	input  wire epsc_pkg::stage_load_t load,
	input  wire logic [25:0]           days_off,
	input  wire logic [16:0]           sod,
	output logic signed [16:0]         year_since_1900,
	output logic [3:0]                 month_index,
	output logic [4:0]                 day_of_month,
	output epsc_pkg::tod_t             tod
);

	logic [25:0] z_s6, w_s6;
	logic [34:0] ps_s6;
	logic [16:0] sod_s6;

	logic [52:0] pz_s7, pw_s7;
	logic [25:0] z_s7, w_s7;
	logic [10:0] m_s7;
	logic [5:0]  sec_s7;

	logic [7:0]  era_s8;
	logic [17:0] doe_s8;
	logic [2:0]  wd_s8;
	logic [22:0] pm_s8;
	logic [10:0] m_s8;
	logic [5:0]  sec_s8;

	logic [36:0] pa_s9, pb_s9;
	logic [17:0] doe_s9;
	logic [7:0]  era_s9;
	epsc_pkg::tod_t tod_s9;

	logic [36:0] px_s10;
	logic [17:0] doe_s10;
	logic [7:0]  era_s10;
	epsc_pkg::tod_t tod_s10;

	logic [8:0]  doy_s11;
	logic [16:0] year_s11;
	epsc_pkg::tod_t tod_s11;

	logic [22:0] p153_s12;
	logic [8:0]  doy_s12;
	logic [16:0] year_s12;
	epsc_pkg::tod_t tod_s12;

	logic [22:0] p5_s13;
	logic [3:0]  mp_s13;
	logic [8:0]  doy_s13;
	logic [16:0] year_s13;
	epsc_pkg::tod_t tod_s13;

	logic signed [16:0] year_s14;
	logic [3:0]  month_s14;
	logic [4:0]  mday_s14;
	epsc_pkg::tod_t tod_s14;

	logic [10:0] m_w;
	logic [16:0] sec_w;
	logic [7:0]  era_w;
	logic [25:0] doe_w;
	logic [23:0] qw_w;
	logic [25:0] wd_w;
	logic [4:0]  hour_w;
	logic [10:0] minute_w;
	logic [6:0]  qa_w;
	logic [2:0]  qb_w;
	logic        last_w;
	logic [17:0] x_w;
	logic [8:0]  yoe_w;
	logic [18:0] pc_w;
	logic [1:0]  cent_w;
	logic [17:0] yday_w;
	logic [17:0] doy_w;
	logic [10:0] d5_w;
	logic [3:0]  mp_w;
	logic [10:0] t5_w;
	logic [8:0]  dm_w;
	logic [8:0]  mday_w;

	// Stage 6: rebias the day count onto era boundaries and start the time split.
	always_ff @(posedge clk) begin
		if (load[5]) begin
			z_s6   <= days_off + epsc_pkg::DayBias[25:0];
			w_s6   <= days_off + epsc_pkg::WdayBias[25:0];
			ps_s6  <= 35'(sod) * 35'(epsc_pkg::Recip60s[17:0]);
			sod_s6 <= sod;
		end
	end

	assign m_w   = ps_s6[epsc_pkg::SodSh +: 11];
	assign sec_w = sod_s6 - 17'(m_w) * 17'd60;

	always_ff @(posedge clk) begin
		if (load[6]) begin
			pz_s7  <= 53'(z_s6) * 53'(epsc_pkg::RecipEra[26:0]);
			pw_s7  <= 53'(w_s6) * 53'(epsc_pkg::Recip7[26:0]);
			z_s7   <= z_s6;
			w_s7   <= w_s6;
			m_s7   <= m_w;
			sec_s7 <= sec_w[5:0];
		end
	end

	assign era_w = pz_s7[epsc_pkg::EraSh +: 8];
	assign doe_w = z_s7 - 26'(era_w) * 26'(epsc_pkg::DaysPerEra);
	assign qw_w  = pw_s7[epsc_pkg::WdSh +: 24];
	assign wd_w  = w_s7 - 26'(qw_w) * 26'd7;

	always_ff @(posedge clk) begin
		if (load[7]) begin
			era_s8 <= era_w;
			doe_s8 <= doe_w[17:0];
			wd_s8  <= wd_w[2:0];
			pm_s8  <= 23'(m_s7) * 23'(epsc_pkg::Recip60m[11:0]);
			m_s8   <= m_s7;
			sec_s8 <= sec_s7;
		end
	end

	assign hour_w   = pm_s8[epsc_pkg::MinSh +: 5];
	assign minute_w = m_s8 - 11'(hour_w) * 11'd60;

	always_ff @(posedge clk) begin
		if (load[8]) begin
			pa_s9  <= 37'(doe_s8) * 37'(epsc_pkg::Recip1460[18:0]);
			pb_s9  <= 37'(doe_s8) * 37'(epsc_pkg::Recip36524[18:0]);
			doe_s9 <= doe_s8;
			era_s9 <= era_s8;
			tod_s9 <= '{hour: hour_w, minute: minute_w[5:0], second: sec_s8,
				weekday: wd_s8};
		end
	end

	// The last day of an era is the only one that reaches a full 146096.
	assign qa_w   = pa_s9[epsc_pkg::C1460Sh +: 7];
	assign qb_w   = pb_s9[epsc_pkg::C36524Sh +: 3];
	assign last_w = (doe_s9 == 18'(epsc_pkg::DaysPerEra - 64'd1));
	assign x_w    = doe_s9 - 18'(qa_w) + 18'(qb_w) - 18'(last_w);

	always_ff @(posedge clk) begin
		if (load[9]) begin
			px_s10  <= 37'(x_w) * 37'(epsc_pkg::Recip365[18:0]);
			doe_s10 <= doe_s9;
			era_s10 <= era_s9;
			tod_s10 <= tod_s9;
		end
	end

	assign yoe_w  = px_s10[epsc_pkg::YoeSh +: 9];
	assign pc_w   = 19'(yoe_w) * 19'(epsc_pkg::Recip100[9:0]);
	assign cent_w = pc_w[epsc_pkg::CentSh +: 2];
	assign yday_w = 18'(yoe_w) * 18'd365 + 18'(yoe_w[8:2]) - 18'(cent_w);
	assign doy_w  = doe_s10 - yday_w;

	always_ff @(posedge clk) begin
		if (load[10]) begin
			doy_s11  <= doy_w[8:0];
			year_s11 <= 17'(era_s10) * 17'd400 + 17'(yoe_w) - epsc_pkg::YearBias[16:0];
			tod_s11  <= tod_s10;
		end
	end

	assign d5_w = 11'(doy_s11) * 11'd5 + 11'd2;

	always_ff @(posedge clk) begin
		if (load[11]) begin
			p153_s12 <= 23'(d5_w) * 23'(epsc_pkg::Recip153[11:0]);
			doy_s12  <= doy_s11;
			year_s12 <= year_s11;
			tod_s12  <= tod_s11;
		end
	end

	assign mp_w = p153_s12[epsc_pkg::MpSh +: 4];
	assign t5_w = 11'(mp_w) * 11'd153 + 11'd2;

	always_ff @(posedge clk) begin
		if (load[12]) begin
			p5_s13   <= 23'(t5_w) * 23'(epsc_pkg::Recip5[11:0]);
			mp_s13   <= mp_w;
			doy_s13  <= doy_s12;
			year_s13 <= year_s12;
			tod_s13  <= tod_s12;
		end
	end

	// Months count from March; January and February belong to the next year.
	assign dm_w   = p5_s13[epsc_pkg::Md5Sh +: 9];
	assign mday_w = doy_s13 - dm_w + 9'd1;

	always_ff @(posedge clk) begin
		if (load[13]) begin
			mday_s14  <= mday_w[4:0];
			month_s14 <= (mp_s13 < 4'd10) ? (mp_s13 + 4'd2) : (mp_s13 - 4'd10);
			year_s14  <= year_s13 + 17'(mp_s13 >= 4'd10);
			tod_s14   <= tod_s13;
		end
	end

	assign year_since_1900 = year_s14;
	assign month_index     = month_s14;
	assign day_of_month    = mday_s14;
	assign tod             = tod_s14;

endmodule

`default_nettype wire

[rtl/epoch_seconds_to_civil_time.sv]
// Top level of the epoch-seconds to civil-time converter: stream ports, valid
// bits and stall control. Depends on epsc_pkg, epsc_day_split and epsc_calendar.
`default_nettype none

// Channel   Direction  Data bits  Content
// s_axis    in         48         epoch_seconds, signed seconds since 1970-01-01 UTC
// m_axis    out        48         civil date, time of day and weekday
//
// Every beat passes through 14 register stages, and one beat is taken in every
// cycle while the output takes beats or a stage is empty. The depth is set by
// the chain of constant divisions, most a reciprocal multiply followed in the
// next stage by the step that uses its quotient.
// Reset clears only the stage valid bits; data registers keep whatever they hold.
// When m_axis stalls, empty stages still move forward, so input beats are taken
// until all stages are full; a full stage holds when all later stages are full.

module epoch_seconds_to_civil_time (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [40:0] epoch_seconds, [47:41] unused
	input  wire logic [47:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [16:0] year_since_1900, [20:17] month_index, [25:21] day_of_month,
	// [30:26] hour_of_day, [36:31] minute_of_hour, [42:37] second_of_minute,
	// [45:43] weekday, [47:46] zero
	output logic [47:0]      m_axis_tdata
);

	localparam int Depth = epsc_pkg::NumStages;

	logic [Depth-1:0]      valid_q;
	epsc_pkg::stage_load_t stage_rdy;

	logic [25:0]        days_off;
	logic [16:0]        sod;
	logic signed [16:0] year_since_1900;
	logic [3:0]         month_index;
	logic [4:0]         day_of_month;
	epsc_pkg::tod_t     tod;

	// A stage may load when some stage from it to the output is empty, or the
	// output beat leaves in this cycle.
	for (genvar g = 0; g < Depth; g++) begin : g_rdy
		assign stage_rdy[g] = m_axis_tready | ~(&valid_q[Depth-1:g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (stage_rdy & {valid_q[Depth-2:0], s_axis_tvalid}) |
				(~stage_rdy & valid_q);
		end
	end

	epsc_day_split u_day_split (
		.clk           (clk),
		.load          (stage_rdy),
		.epoch_seconds (s_axis_tdata[40:0]),
		.days_off      (days_off),
		.sod           (sod)
	);

	epsc_calendar u_calendar (
		.clk             (clk),
		.load            (stage_rdy),
		.days_off        (days_off),
		.sod             (sod),
		.year_since_1900 (year_since_1900),
		.month_index     (month_index),
		.day_of_month    (day_of_month),
		.tod             (tod)
	);

	assign s_axis_tready = stage_rdy[0];
	assign m_axis_tvalid = valid_q[Depth-1];
	assign m_axis_tdata  = {2'b00, tod.weekday, tod.second, tod.minute, tod.hour,
		day_of_month, month_index, year_since_1900};

endmodule

`default_nettype wire

[rtl/epsc_port_monitor.sv]
// Port-level assertions for the epoch-seconds to civil-time converter, bound
// to the top level. Depends only on the top level's port names.
`default_nettype none

module epsc_port_monitor (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);

	// A stalled output beat stays offered.
	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat withdrawn while stalled");

	// A stalled output beat keeps its data.
	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	// With the output stage empty the pipeline always has room for a beat.
	a_room_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with an empty output stage");

	// Month, time and weekday are in range, the day is nonzero, the pad bits are zero.
	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[20:17] <= 4'd11) &&
			(m_axis_tdata[25:21] != 5'd0) &&
			(m_axis_tdata[30:26] <= 5'd23) &&
			(m_axis_tdata[36:31] <= 6'd59) &&
			(m_axis_tdata[42:37] <= 6'd59) &&
			(m_axis_tdata[45:43] <= 3'd6) &&
			(m_axis_tdata[47:46] == 2'd0))
		else $error("output field out of range");

endmodule

bind epoch_seconds_to_civil_time epsc_port_monitor u_port_monitor (.*);

`default_nettype wire
